FILE: sv/tracker_peer_table_assert.svh
// Assertion macros for the tracker peer table
`ifndef TRACKER_PEER_TABLE_ASSERT_SVH
`define TRACKER_PEER_TABLE_ASSERT_SVH
`define TPT_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define TPT_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

FILE: sv/tpt_pkg.sv
// ---------------------------------------------------------------------------
// tpt_pkg
// Types and constants shared by the tracker peer table modules.
// ---------------------------------------------------------------------------
package tpt_pkg;
    localparam int ENTRIES = 16;
    localparam int SLOT_W  = $clog2(ENTRIES);

    localparam logic [1:0] ACT_HANDSHAKE = 2'd0;
    localparam logic [1:0] ACT_DATA      = 2'd1;
    localparam logic [1:0] ACT_TICK      = 2'd2;
    localparam logic [1:0] ACT_IGNORED   = 2'd3;

    localparam logic [1:0] PST_OK        = 2'd0;
    localparam logic [1:0] PST_PERM      = 2'd1;
    localparam logic [1:0] PST_TRANSIENT = 2'd2;
    localparam logic [1:0] PST_SPARE     = 2'd3;

    localparam logic [2:0] K_ACCEPT    = 3'd0;
    localparam logic [2:0] K_REFUSE    = 3'd1;
    localparam logic [2:0] K_MATCH     = 3'd2;
    localparam logic [2:0] K_NOMATCH   = 3'd3;
    localparam logic [2:0] K_STATUS    = 3'd4;
    localparam logic [2:0] K_HEARTBEAT = 3'd5;
    localparam logic [2:0] K_TICKDONE  = 3'd6;

    localparam logic [1:0] CFG_TIMEOUT  = 2'd0;
    localparam logic [1:0] CFG_INTERVAL = 2'd1;
    localparam logic [1:0] CFG_HB_EN    = 2'd2;

    typedef struct packed {
        logic [1:0]  action;
        logic [47:0] hw_address;
        logic [31:0] net_address;
        logic [15:0] net_port;
        logic [7:0]  pair_id;
        logic [1:0]  pair_status;
        logic [31:0] now_ms;
    } t_in;

    typedef struct packed {
        logic [2:0]  kind;
        logic [3:0]  slot;
        logic [7:0]  tracker_id;
        logic        is_new;
        logic        online;
        logic [31:0] peer_net_address;
        logic [15:0] peer_port;
        logic [63:0] heartbeat_seq;
        logic        last;
    } t_out;

    typedef struct packed {
        logic [47:0] hw;
        logic [31:0] net;
        logic [15:0] port;
        logic [7:0]  tracker;
        logic [31:0] seen;
        logic [31:0] beat;
    } t_entry;

    typedef struct packed {
        logic             we;
        logic [SLOT_W-1:0] waddr;
        t_entry           wdata;
        logic [SLOT_W-1:0] raddr;
    } t_mem_req;
endpackage

FILE: sv/tpt_entry_ram.sv
// ---------------------------------------------------------------------------
// tpt_entry_ram
// Entry store: one write port, one registered read port.
// ---------------------------------------------------------------------------
module tpt_entry_ram
    import tpt_pkg::*;
(
    input  logic     i_clk,
    input  t_mem_req i_req,
    output t_entry   o_rdata
);
    t_entry r_mem [ENTRIES];

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        o_rdata <= r_mem[i_req.raddr];
    end
endmodule

FILE: sv/tpt_ctrl.sv
// ---------------------------------------------------------------------------
// tpt_ctrl
// Sequencer: scans the entry store and emits results.
// ---------------------------------------------------------------------------
module tpt_ctrl
    import tpt_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in       i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out      o_out_data,
    input  logic [30:0] i_timeout,
    input  logic [30:0] i_interval,
    input  logic      i_hb_en,
    output t_mem_req  o_req,
    input  t_entry    i_rdata
);
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1; // read issued, data next cycle
    localparam logic [2:0] S_DECIDE = 3'd2;
    localparam logic [2:0] S_DUP   = 3'd3;
    localparam logic [2:0] S_FINAL = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;
    localparam logic [2:0] S_WRITE = 3'd6;

    logic [2:0]  r_state;
    t_in         r_item;
    logic [SLOT_W:0] r_idx;       // one bit wider to hold ENTRIES
    logic        r_rdv;           // read data valid for slot r_idx-1
    logic [ENTRIES-1:0] r_used, r_online;
    logic        r_found;
    logic [SLOT_W-1:0] r_hit, r_free;
    logic        r_have_free;
    logic [47:0] r_ref_addr;
    logic        r_ref_valid;
    logic [63:0] r_beat_cnt;
    logic        r_ovalid;
    t_out        r_out;
    logic        r_new;
    t_entry      r_ent;
    logic        r_hb_pend;       // tick: heartbeat still to emit for r_ent
    logic [SLOT_W-1:0] r_cur;

    logic [SLOT_W-1:0] cur;
    logic out_free;
    logic [31:0] d_ent, d_beat;
    logic alive, due;
    logic ref_hit, refuse_hs;
    logic emit;
    t_entry fin_ent;

    assign out_free   = !r_ovalid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;
    assign cur = r_idx[SLOT_W-1:0] - 1'b1;

    // liveness and heartbeat timing of the entry held in r_ent
    assign d_ent = r_item.now_ms - r_ent.seen;
    assign d_beat = r_item.now_ms - r_ent.beat;
    assign alive = ($signed(d_ent) < $signed({1'b0, i_timeout}))
                && ($signed(d_ent) > -$signed({1'b0, i_timeout}));
    assign due = i_hb_en && (r_ent.net != 32'd0)
              && ($signed(d_beat) >= $signed({1'b0, i_interval}));

    assign ref_hit = r_ref_valid && (r_ref_addr == r_item.hw_address);
    assign refuse_hs = !r_found && (ref_hit || !r_have_free || r_item.pair_status != PST_OK);

    function automatic t_out mk(input logic [2:0] k, input logic [SLOT_W-1:0] s,
                                input t_entry e, input logic nw, input logic on,
                                input logic [63:0] sq, input logic lst);
        t_out o;
        o = '0;
        o.kind = k;
        if (k != K_REFUSE && k != K_NOMATCH && k != K_TICKDONE) begin
            o.slot = s;
            o.tracker_id = e.tracker;
            o.peer_net_address = e.net;
            o.peer_port = e.port;
        end
        o.is_new = nw;
        o.online = on;
        o.heartbeat_seq = sq;
        o.last = lst;
        return o;
    endfunction

    // target entry as written back by a handshake or data transaction
    always_comb begin
        fin_ent = i_rdata;
        fin_ent.seen = r_item.now_ms;
        if (r_item.action == ACT_HANDSHAKE) begin
            fin_ent.beat = r_item.now_ms;
            fin_ent.net = r_item.net_address;
            fin_ent.port = r_item.net_port;
            if (r_new) begin
                fin_ent.hw = r_item.hw_address;
                fin_ent.tracker = r_item.pair_id;
            end
        end
    end

    // a result is loaded this cycle when emit and out_free are both set
    always_comb begin
        emit = 1'b0;
        case (r_state)
            S_SCAN: begin
                emit = (r_item.action == ACT_TICK) && !r_rdv
                    && (r_idx == (SLOT_W+1)'(ENTRIES));
            end
            S_DECIDE: begin
                if (r_item.action == ACT_TICK) emit = (alive != r_online[r_cur]);
                else if (r_item.action == ACT_DATA) emit = !r_found;
                else emit = refuse_hs;
            end
            S_OUT: begin
                emit = (r_item.action != ACT_TICK) || (r_hb_pend && due);
            end
            default: emit = 1'b0;
        endcase
    end

    always_comb begin
        o_req = '0;
        o_req.raddr = r_idx[SLOT_W-1:0];
        if (r_state == S_FINAL) o_req.raddr = r_hit;
        // write requests
        if (r_state == S_DUP && r_rdv && r_used[cur] && !(r_found && cur == r_hit)
            && i_rdata.net == r_item.net_address) begin
            o_req.we = 1'b1;
            o_req.waddr = cur;
            o_req.wdata = i_rdata;
            o_req.wdata.net = 32'd0;
        end
        if (r_state == S_WRITE) begin
            o_req.we = 1'b1;
            o_req.waddr = r_cur;
            o_req.wdata = r_ent;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_used <= '0;
            r_online <= '0;
            r_ref_valid <= 1'b0;
            r_ref_addr <= '0;
            r_beat_cnt <= '0;
            r_ovalid <= 1'b0;
            r_rdv <= 1'b0;
            r_hb_pend <= 1'b0;
        end else begin
            r_ovalid <= (emit && out_free) || (r_ovalid && i_out_stall);
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_item <= i_in_data;
                        r_idx <= '0;
                        r_rdv <= 1'b0;
                        r_found <= 1'b0;
                        r_have_free <= 1'b0;
                        r_new <= 1'b0;
                        if (i_in_data.action == ACT_IGNORED) r_state <= S_IDLE;
                        else r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    // lookup pass over all slots (handshake/data) or tick walk
                    if (r_item.action == ACT_TICK) begin
                        if (r_rdv) begin
                            r_ent <= i_rdata;
                            r_cur <= cur;
                            r_rdv <= 1'b0;
                            if (r_used[cur]) r_state <= S_DECIDE;
                        end else if (r_idx == (SLOT_W+1)'(ENTRIES)) begin
                            if (out_free) begin
                                r_out <= mk(K_TICKDONE, '0, '0, 1'b0, 1'b0, '0, 1'b1);
                                r_state <= S_IDLE;
                            end
                        end else begin
                            r_idx <= r_idx + 1'b1;
                            r_rdv <= 1'b1;
                        end
                    end else begin
                        if (r_rdv) begin
                            if (r_used[cur] && !r_found) begin
                                if (r_item.action == ACT_HANDSHAKE
                                    && i_rdata.hw == r_item.hw_address) begin
                                    r_found <= 1'b1;
                                    r_hit <= cur;
                                end
                                if (r_item.action == ACT_DATA && r_item.net_address != 0
                                    && i_rdata.net == r_item.net_address) begin
                                    r_found <= 1'b1;
                                    r_hit <= cur;
                                end
                            end
                            if (!r_used[cur] && !r_have_free) begin
                                r_have_free <= 1'b1;
                                r_free <= cur;
                            end
                        end
                        if (r_idx == (SLOT_W+1)'(ENTRIES)) begin
                            r_rdv <= 1'b0;
                            r_state <= S_DECIDE;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                            r_rdv <= 1'b1;
                        end
                    end
                end
                S_DECIDE: begin
                    if (r_item.action == ACT_TICK) begin
                        // r_ent holds entry r_cur
                        if (out_free) begin
                            if (alive != r_online[r_cur]) begin
                                r_online[r_cur] <= alive;
                                r_out <= mk(K_STATUS, r_cur, r_ent, 1'b0, alive,
                                            '0, 1'b0);
                            end
                            r_hb_pend <= alive;
                            r_state <= S_OUT;
                        end
                    end else if (r_item.action == ACT_DATA) begin
                        if (!r_found) begin
                            if (out_free) begin
                                r_out <= mk(K_NOMATCH, '0, '0, 1'b0, 1'b0, '0, 1'b1);
                                r_state <= S_IDLE;
                            end
                        end else begin
                            r_state <= S_FINAL;
                            r_rdv <= 1'b0;
                        end
                    end else begin
                        if (refuse_hs) begin
                            if (out_free) begin
                                if (!ref_hit
                                    && (!r_have_free || r_item.pair_status == PST_PERM)) begin
                                    r_ref_valid <= 1'b1;
                                    r_ref_addr <= r_item.hw_address;
                                end
                                r_out <= mk(K_REFUSE, '0, '0, 1'b0, 1'b0, '0, 1'b1);
                                r_state <= S_IDLE;
                            end
                        end else begin
                            r_idx <= '0;
                            r_rdv <= 1'b0;
                            r_state <= S_DUP;
                        end
                    end
                end
                S_DUP: begin
                    // clear duplicate network addresses, one slot per read
                    if (r_idx == (SLOT_W+1)'(ENTRIES) && r_rdv) begin
                        r_rdv <= 1'b0;
                        r_state <= S_FINAL;
                        if (!r_found) begin
                            r_hit <= r_free;
                            r_found <= 1'b1;
                            r_new <= 1'b1;
                        end
                    end else begin
                        if (r_idx != (SLOT_W+1)'(ENTRIES)) r_idx <= r_idx + 1'b1;
                        r_rdv <= 1'b1;
                    end
                end
                S_FINAL: begin
                    // read of target entry issued; wait for data
                    if (r_rdv) begin
                        r_ent <= fin_ent;
                        r_cur <= r_hit;
                        if (r_item.action == ACT_HANDSHAKE && r_new) begin
                            r_used[r_hit] <= 1'b1;
                            r_online[r_hit] <= 1'b0;
                        end
                        r_rdv <= 1'b0;
                        r_state <= S_OUT;
                    end else begin
                        r_rdv <= 1'b1;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        if (r_item.action == ACT_TICK) begin
                            if (r_hb_pend && due) begin
                                r_out <= mk(K_HEARTBEAT, r_cur, r_ent, 1'b0, 1'b0,
                                            r_beat_cnt, 1'b0);
                                r_beat_cnt <= r_beat_cnt + 64'd1;
                                r_ent.beat <= r_item.now_ms;
                                r_state <= S_WRITE;
                            end else begin
                                r_state <= S_SCAN;
                            end
                            r_hb_pend <= 1'b0;
                        end else begin
                            if (r_item.action == ACT_HANDSHAKE) begin
                                r_out <= mk(K_ACCEPT, r_cur, r_ent, r_new, 1'b0,
                                            r_beat_cnt, 1'b1);
                                r_beat_cnt <= r_beat_cnt + 64'd1;
                            end else begin
                                r_out <= mk(K_MATCH, r_cur, r_ent, 1'b0, 1'b0, '0, 1'b1);
                            end
                            r_state <= S_WRITE;
                        end
                    end
                end
                S_WRITE: begin
                    r_state <= (r_item.action == ACT_TICK) ? S_SCAN : S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

FILE: sv/tracker_peer_table.sv
// A tick walks every slot, checks each used slot for a status change and a due heartbeat,
// then emits tick done.
// One item at a time, set by the slot scan over the single RAM read port.
// Synchronous active-low reset clears used/online bits, refused cache, heartbeat counter
// and config to 6000 ms / 1000 ms / enabled.
// ---------------------------------------------------------------------------
// tracker_peer_table
// Peer table top level: config registers, sequencer and entry RAM.
// ---------------------------------------------------------------------------
module tracker_peer_table
    import tpt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in         i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out        o_out_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    logic [30:0] r_timeout, r_interval;
    logic        r_hb_en;
    t_mem_req    req;
    t_entry      rdata;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= 31'd6000;
            r_interval <= 31'd1000;
            r_hb_en <= 1'b1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_TIMEOUT:  r_timeout <= i_cfg_data[30:0];
                CFG_INTERVAL: r_interval <= i_cfg_data[30:0];
                CFG_HB_EN:    r_hb_en <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    tpt_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_in_valid, .o_in_stall, .i_in_data,
        .o_out_valid, .i_out_stall, .o_out_data,
        .i_timeout(r_timeout), .i_interval(r_interval), .i_hb_en(r_hb_en),
        .o_req(req), .i_rdata(rdata)
    );

    tpt_entry_ram u_ram (.i_clk, .i_req(req), .o_rdata(rdata));
endmodule

FILE: sv/tpt_checker.sv
// ---------------------------------------------------------------------------
// tpt_checker
// Port-level checks for the tracker peer table.
// ---------------------------------------------------------------------------
`include "tracker_peer_table_assert.svh"
module tpt_checker
    import tpt_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_stall,
    input t_in  i_in_data,
    input logic o_out_valid,
    input logic i_out_stall,
    input t_out o_out_data
);
    `TPT_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n,
        i_in_valid && !o_in_stall && (i_in_data.action != ACT_IGNORED), o_in_stall)
    `TPT_ASSERT_IMP(a_kind_range, i_clk, i_rst_n, o_out_valid, o_out_data.kind <= K_TICKDONE)
    `TPT_ASSERT_IMP(a_done_last, i_clk, i_rst_n,
        o_out_valid && o_out_data.kind == K_TICKDONE, o_out_data.last)
    `TPT_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n,
        o_out_valid && i_out_stall, o_out_valid && $stable(o_out_data))
endmodule

bind tracker_peer_table tpt_checker u_chk (
    .i_clk, .i_rst_n, .i_in_valid, .o_in_stall, .i_in_data,
    .o_out_valid, .i_out_stall, .o_out_data
);
